/* hw/rtl/f2pm_pkg.sv */
// ----------------------------------------------------------------------------
// f2pm_pkg
// Shared types, codes and constants of the two-dimensional prefix-max tree.
// ----------------------------------------------------------------------------
package f2pm_pkg;

  localparam int COORD_W        = 11;
  localparam int VALUE_W        = 48;
  localparam int SIZE_W         = 11;
  localparam int MAX_SIZE_DEF   = 1024;
  localparam int VALUE_BITS_DEF = 48;
  localparam int APB_AW         = 2;
  localparam int APB_DW         = 32;
  localparam int STEP_W         = 4;

  localparam logic [SIZE_W-1:0] SIZE_RESET       = 11'd1024;
  localparam logic [APB_AW-1:0] ADDR_SIZE_IN_USE = 2'd0;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic [COORD_W-1:0]        x_coord;
    logic [COORD_W-1:0]        y_coord;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] max_value;
    logic                      found;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_LOAD,
    OP_NOP,
    OP_READ,
    OP_UPD_WRITE,
    OP_X_UP,
    OP_FOLD,
    OP_X_DN,
    OP_EMIT,
    OP_CLEAR
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_IN,
    C_WAIT_OUT,
    C_CLEAR,
    C_QUERY,
    C_REJECT,
    C_Y_UP_MORE,
    C_X_UP_DONE,
    C_Y_DN_MORE,
    C_X_DN_DONE,
    C_Q_EMPTY
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic is_query;
    logic upd_ok;
    logic y_up_more;
    logic x_up_more;
    logic y_dn_more;
    logic x_dn_more;
    logic q_empty;
    logic out_free;
    logic clr_last;
  } status_t;

endpackage

/* hw/rtl/f2pm_sequencer.sv */
// ----------------------------------------------------------------------------
// f2pm_sequencer
// Step counter and control store that walk the tree for updates and queries.
// ----------------------------------------------------------------------------
module f2pm_sequencer (
  input  logic              clk,
  input  logic              rst,
  input  f2pm_pkg::status_t status,
  output f2pm_pkg::ctrl_t   ctrl
);

  localparam logic [f2pm_pkg::STEP_W-1:0] S_IDLE   = 4'd0;
  localparam logic [f2pm_pkg::STEP_W-1:0] S_DISP   = 4'd1;
  localparam logic [f2pm_pkg::STEP_W-1:0] S_UCHK   = 4'd2;
  localparam logic [f2pm_pkg::STEP_W-1:0] S_U_RD   = 4'd3;
  localparam logic [f2pm_pkg::STEP_W-1:0] S_U_WR   = 4'd4;
  localparam logic [f2pm_pkg::STEP_W-1:0] S_U_NX   = 4'd5;
  localparam logic [f2pm_pkg::STEP_W-1:0] S_U_RD2  = 4'd6;
  localparam logic [f2pm_pkg::STEP_W-1:0] S_Q_INIT = 4'd7;
  localparam logic [f2pm_pkg::STEP_W-1:0] S_Q_RD   = 4'd8;
  localparam logic [f2pm_pkg::STEP_W-1:0] S_Q_ACC  = 4'd9;
  localparam logic [f2pm_pkg::STEP_W-1:0] S_Q_NX   = 4'd10;
  localparam logic [f2pm_pkg::STEP_W-1:0] S_Q_RD2  = 4'd11;
  localparam logic [f2pm_pkg::STEP_W-1:0] S_Q_DONE = 4'd12;
  localparam logic [f2pm_pkg::STEP_W-1:0] S_CLR    = 4'd13;

  function automatic f2pm_pkg::ctrl_t rom_word(input logic [f2pm_pkg::STEP_W-1:0] step);
    f2pm_pkg::ctrl_t w;
    unique case (step)
      S_IDLE:   w = '{f2pm_pkg::OP_LOAD,      f2pm_pkg::C_WAIT_IN,   S_IDLE};
      S_DISP:   w = '{f2pm_pkg::OP_NOP,       f2pm_pkg::C_QUERY,     S_Q_INIT};
      S_UCHK:   w = '{f2pm_pkg::OP_NOP,       f2pm_pkg::C_REJECT,    S_IDLE};
      S_U_RD:   w = '{f2pm_pkg::OP_READ,      f2pm_pkg::C_NEXT,      S_IDLE};
      S_U_WR:   w = '{f2pm_pkg::OP_UPD_WRITE, f2pm_pkg::C_Y_UP_MORE, S_U_RD};
      S_U_NX:   w = '{f2pm_pkg::OP_X_UP,      f2pm_pkg::C_X_UP_DONE, S_IDLE};
      S_U_RD2:  w = '{f2pm_pkg::OP_READ,      f2pm_pkg::C_JUMP,      S_U_WR};
      S_Q_INIT: w = '{f2pm_pkg::OP_NOP,       f2pm_pkg::C_Q_EMPTY,   S_Q_DONE};
      S_Q_RD:   w = '{f2pm_pkg::OP_READ,      f2pm_pkg::C_NEXT,      S_IDLE};
      S_Q_ACC:  w = '{f2pm_pkg::OP_FOLD,      f2pm_pkg::C_Y_DN_MORE, S_Q_RD};
      S_Q_NX:   w = '{f2pm_pkg::OP_X_DN,      f2pm_pkg::C_X_DN_DONE, S_Q_DONE};
      S_Q_RD2:  w = '{f2pm_pkg::OP_READ,      f2pm_pkg::C_JUMP,      S_Q_ACC};
      S_Q_DONE: w = '{f2pm_pkg::OP_EMIT,      f2pm_pkg::C_WAIT_OUT,  S_IDLE};
      S_CLR:    w = '{f2pm_pkg::OP_CLEAR,     f2pm_pkg::C_CLEAR,     S_IDLE};
      default:  w = '{f2pm_pkg::OP_NOP,       f2pm_pkg::C_JUMP,      S_IDLE};
    endcase
    return w;
  endfunction

  logic [f2pm_pkg::STEP_W-1:0] pc;
  logic [f2pm_pkg::STEP_W-1:0] pc_next;
  logic [f2pm_pkg::STEP_W-1:0] pc_inc;

  assign ctrl   = rom_word(pc);
  assign pc_inc = pc + f2pm_pkg::STEP_W'(1);

  always_comb begin
    case (ctrl.cond)
      f2pm_pkg::C_NEXT:      pc_next = pc_inc;
      f2pm_pkg::C_JUMP:      pc_next = ctrl.target;
      f2pm_pkg::C_WAIT_IN:   pc_next = status.accept ? pc_inc : pc;
      f2pm_pkg::C_WAIT_OUT:  pc_next = status.out_free ? ctrl.target : pc;
      f2pm_pkg::C_CLEAR:     pc_next = status.clr_last ? ctrl.target : pc;
      f2pm_pkg::C_QUERY:     pc_next = status.is_query ? ctrl.target : pc_inc;
      f2pm_pkg::C_REJECT:    pc_next = !status.upd_ok ? ctrl.target : pc_inc;
      f2pm_pkg::C_Y_UP_MORE: pc_next = status.y_up_more ? ctrl.target : pc_inc;
      f2pm_pkg::C_X_UP_DONE: pc_next = !status.x_up_more ? ctrl.target : pc_inc;
      f2pm_pkg::C_Y_DN_MORE: pc_next = status.y_dn_more ? ctrl.target : pc_inc;
      f2pm_pkg::C_X_DN_DONE: pc_next = !status.x_dn_more ? ctrl.target : pc_inc;
      f2pm_pkg::C_Q_EMPTY:   pc_next = status.q_empty ? ctrl.target : pc_inc;
      default:               pc_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_CLR;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* hw/rtl/fenwick_2d_prefix_max.sv */
// ----------------------------------------------------------------------------
// fenwick_2d_prefix_max
// Two-dimensional Fenwick tree that keeps a running maximum of signed values.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_stall, req) carries updates and prefix
// maximum queries. A transfer happens when req_valid is high and req_stall is
// low. Updates produce nothing; each query produces one transfer on the
// response channel (rsp_valid, rsp_stall, rsp).
// Items are handled one at a time. Along each axis an item walks at most
// about log2 of the size plus one tree nodes, and every node costs a read
// of the tree memory and then a write or a fold.
// A finished response waits in an output register while rsp_stall is high;
// the next request is already taken meanwhile, and only a following query
// waits for that register to free up.
// After reset the tree memory is cleared one node per cycle, all MAX_SIZE
// rounded up to a power of two and squared nodes (1048576 by default),
// during which req_stall stays high. The APB register size_in_use is
// writable at all times.
// ----------------------------------------------------------------------------
module fenwick_2d_prefix_max #(
  parameter int MAX_SIZE   = f2pm_pkg::MAX_SIZE_DEF,
  parameter int VALUE_BITS = f2pm_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  f2pm_pkg::req_t              req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output f2pm_pkg::rsp_t              rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [f2pm_pkg::APB_AW-1:0] paddr,
  input  logic [f2pm_pkg::APB_DW-1:0] pwdata,
  output logic [f2pm_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int MEM_AW = 2 * IDX_W;
  localparam int DEPTH  = 1 << MEM_AW;
  localparam int CW     = $clog2(MAX_SIZE + 1) + 1;
  localparam int CMP_W  = (CW > f2pm_pkg::COORD_W) ? CW : f2pm_pkg::COORD_W;

  localparam logic [CMP_W-1:0]      MAX_CMP  = CMP_W'(MAX_SIZE);
  localparam logic [VALUE_BITS-1:0] EMPTY_PAT = {1'b1, {(VALUE_BITS - 1){1'b0}}};

  f2pm_pkg::ctrl_t   ctrl;
  f2pm_pkg::status_t status;

  logic [f2pm_pkg::SIZE_W-1:0] size_in_use;
  logic                        cfg_write;

  logic [CMP_W-1:0] size_cmp;
  logic [CMP_W-1:0] n_cmp;
  logic [CW-1:0]    n;
  logic [CMP_W-1:0] x_in;
  logic [CMP_W-1:0] y_in;
  logic [CMP_W-1:0] x_clamp;
  logic [CMP_W-1:0] y_clamp;

  logic                         accept;
  logic                         is_query;
  logic                         upd_ok;
  logic [CW-1:0]                x;
  logic [CW-1:0]                y;
  logic [CW-1:0]                y0;
  logic signed [VALUE_BITS-1:0] val;
  logic signed [VALUE_BITS-1:0] best;
  logic                         any;

  logic [CW-1:0] x_up;
  logic [CW-1:0] y_up;
  logic [CW-1:0] x_dn;
  logic [CW-1:0] y_dn;
  logic [CW-1:0] x_m1;
  logic [CW-1:0] y_m1;

  logic [MEM_AW-1:0]  node_addr;
  logic [MEM_AW-1:0]  clr_addr;
  logic [VALUE_BITS:0] node_mem [DEPTH];
  logic [VALUE_BITS:0] rd_q;
  logic                         rd_ok;
  logic signed [VALUE_BITS-1:0] rd_val;

  logic                wr_en;
  logic [MEM_AW-1:0]   wr_addr;
  logic [VALUE_BITS:0] wr_data;
  logic                need_write;
  logic                out_free;
  logic                emit;

  f2pm_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == f2pm_pkg::ADDR_SIZE_IN_USE);
  assign prdata    = (paddr == f2pm_pkg::ADDR_SIZE_IN_USE) ?
                     f2pm_pkg::APB_DW'(size_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_in_use <= f2pm_pkg::SIZE_RESET;
    end else if (cfg_write) begin
      size_in_use <= pwdata[f2pm_pkg::SIZE_W-1:0];
    end
  end

  // Effective size and input range checks.
  assign size_cmp = CMP_W'(size_in_use);
  assign n_cmp    = (size_cmp < MAX_CMP) ? size_cmp : MAX_CMP;
  assign n        = n_cmp[CW-1:0];
  assign x_in     = CMP_W'(req.x_coord);
  assign y_in     = CMP_W'(req.y_coord);
  assign x_clamp  = (x_in > n_cmp) ? n_cmp : x_in;
  assign y_clamp  = (y_in > n_cmp) ? n_cmp : y_in;

  assign req_stall = rst || (ctrl.op != f2pm_pkg::OP_LOAD);
  assign accept    = req_valid && !req_stall;

  // Tree walk steps.
  assign x_up = x + (x & (~x + CW'(1)));
  assign y_up = y + (y & (~y + CW'(1)));
  assign x_dn = x & (x - CW'(1));
  assign y_dn = y & (y - CW'(1));
  assign x_m1 = x - CW'(1);
  assign y_m1 = y - CW'(1);
  assign node_addr = {x_m1[IDX_W-1:0], y_m1[IDX_W-1:0]};

  assign rd_ok  = rd_q[VALUE_BITS];
  assign rd_val = $signed(rd_q[VALUE_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (accept) begin
      is_query <= (req.req_type == f2pm_pkg::REQ_QUERY);
      upd_ok   <= (x_in != '0) && (y_in != '0) && (x_in <= n_cmp) && (y_in <= n_cmp);
      x        <= x_clamp[CW-1:0];
      y        <= y_clamp[CW-1:0];
      y0       <= y_clamp[CW-1:0];
      val      <= VALUE_BITS'($signed(req.value));
    end else begin
      case (ctrl.op)
        f2pm_pkg::OP_UPD_WRITE: y <= y_up;
        f2pm_pkg::OP_FOLD:      y <= y_dn;
        f2pm_pkg::OP_X_UP: begin
          x <= x_up;
          y <= y0;
        end
        f2pm_pkg::OP_X_DN: begin
          x <= x_dn;
          y <= y0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      any <= 1'b0;
    end else if (accept) begin
      any <= 1'b0;
    end else if (ctrl.op == f2pm_pkg::OP_FOLD && rd_ok) begin
      any <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == f2pm_pkg::OP_FOLD && rd_ok && (!any || rd_val > best)) begin
      best <= rd_val;
    end
  end

  // Tree memory: one write port, one registered read port.
  assign need_write = !rd_ok || (rd_val < val);
  assign wr_en   = (ctrl.op == f2pm_pkg::OP_CLEAR) ||
                   (ctrl.op == f2pm_pkg::OP_UPD_WRITE && need_write);
  assign wr_addr = (ctrl.op == f2pm_pkg::OP_CLEAR) ? clr_addr : node_addr;
  assign wr_data = (ctrl.op == f2pm_pkg::OP_CLEAR) ? '0 : {1'b1, val};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == f2pm_pkg::OP_READ) begin
      rd_q <= node_mem[node_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctrl.op == f2pm_pkg::OP_CLEAR) begin
      clr_addr <= clr_addr + MEM_AW'(1);
    end
  end

  // Response register.
  assign out_free = !rsp_valid || !rsp_stall;
  assign emit     = (ctrl.op == f2pm_pkg::OP_EMIT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.max_value <= f2pm_pkg::VALUE_W'(any ? VALUE_BITS'(best) : EMPTY_PAT);
      rsp.found     <= any;
    end
  end

  assign status.accept    = accept;
  assign status.is_query  = is_query;
  assign status.upd_ok    = upd_ok;
  assign status.y_up_more = (y_up <= n);
  assign status.x_up_more = (x_up <= n);
  assign status.y_dn_more = (y_dn != '0);
  assign status.x_dn_more = (x_dn != '0);
  assign status.q_empty   = (x == '0) || (y == '0);
  assign status.out_free  = out_free;
  assign status.clr_last  = (clr_addr == '1);

  // An update only ever writes nodes inside the effective size.
  a_upd_in_range: assert property (@(posedge clk) disable iff (rst)
    (wr_en && ctrl.op == f2pm_pkg::OP_UPD_WRITE) |->
      (x != '0 && y != '0 && x <= n && y <= n))
    else $error("update write outside the tree");

  // Once a request is taken, no second one is taken in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> req_stall)
    else $error("request taken while busy");

  // A new response only follows a query.
  a_rsp_from_query: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !$past(rsp_valid)) |-> is_query)
    else $error("response raised for an update");

  // No request is taken during the clearing pass.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == f2pm_pkg::OP_CLEAR) |-> req_stall)
    else $error("request taken during memory clear");

endmodule

/* tb/fenwick_2d_prefix_max_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_2d_prefix_max_tb
// Self-checking testbench of the two-dimensional prefix-max Fenwick tree.
// ----------------------------------------------------------------------------
// Requests are sent over the request channel while a checker compares every
// response transfer with a prediction kept in a sparse copy of the tree.
// Directed items cover the field extremes and the corner cases. Random phases
// then run at several sizes with random idling and output stalls. One test
// holds the response channel off long enough to stall the request side.
// ----------------------------------------------------------------------------
module fenwick_2d_prefix_max_tb;

  localparam int          TREE_DIM     = f2pm_pkg::MAX_SIZE_DEF;
  localparam int          DRAIN_CYCLES = 400;
  localparam int          LONG_HOLD    = 2500;
  localparam int unsigned CYCLE_LIMIT  = 8000000;
  localparam logic signed [f2pm_pkg::VALUE_W-1:0] VAL_MIN =
    {1'b1, {(f2pm_pkg::VALUE_W-1){1'b0}}};
  localparam logic signed [f2pm_pkg::VALUE_W-1:0] VAL_MAX =
    {1'b0, {(f2pm_pkg::VALUE_W-1){1'b1}}};

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_stall;
  f2pm_pkg::req_t              req       = '0;
  logic                        rsp_valid;
  logic                        rsp_stall = 1'b0;
  f2pm_pkg::rsp_t              rsp;
  logic                        psel      = 1'b0;
  logic                        penable   = 1'b0;
  logic                        pwrite    = 1'b0;
  logic [f2pm_pkg::APB_AW-1:0] paddr     = '0;
  logic [f2pm_pkg::APB_DW-1:0] pwdata    = '0;
  logic [f2pm_pkg::APB_DW-1:0] prdata;
  logic                        pready;

  logic signed [f2pm_pkg::VALUE_W-1:0] node_peak [int];
  logic [f2pm_pkg::SIZE_W-1:0]         size_setting = f2pm_pkg::SIZE_RESET;
  f2pm_pkg::rsp_t                      pending_maxima [$];
  f2pm_pkg::rsp_t                      oldest_max;
  int                                  mismatch_count = 0;
  bit                                  gaps_on        = 1'b1;
  bit                                  stalls_on      = 1'b1;
  bit                                  long_hold_req  = 1'b0;
  int                                  hold_left      = 0;
  int                                  burst_left     = 0;
  int unsigned                         cycle_count    = 0;

  fenwick_2d_prefix_max u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  function automatic int eff_size();
    return (size_setting < TREE_DIM) ? int'(size_setting) : TREE_DIM;
  endfunction

  // Updates raise every covering node; queries fold the prefix nodes.
  function automatic void predict_prefix_max(input f2pm_pkg::req_t item);
    int                                  n;
    int                                  x;
    int                                  y;
    int                                  xs;
    int                                  ys;
    int                                  slot;
    bit                                  any;
    logic signed [f2pm_pkg::VALUE_W-1:0] best;
    f2pm_pkg::rsp_t                      outcome;
    n    = eff_size();
    xs   = int'(item.x_coord);
    ys   = int'(item.y_coord);
    any  = 1'b0;
    best = VAL_MIN;
    if (item.req_type == f2pm_pkg::REQ_UPDATE) begin
      if (xs == 0 || ys == 0 || xs > n || ys > n) return;
      for (x = xs; x <= n; x += x & -x) begin
        for (y = ys; y <= n; y += y & -y) begin
          slot = (x - 1) * TREE_DIM + (y - 1);
          if (!node_peak.exists(slot) || node_peak[slot] < $signed(item.value)) begin
            node_peak[slot] = item.value;
          end
        end
      end
    end else begin
      if (xs > n) xs = n;
      if (ys > n) ys = n;
      for (x = xs; x != 0; x -= x & -x) begin
        for (y = ys; y != 0; y -= y & -y) begin
          slot = (x - 1) * TREE_DIM + (y - 1);
          if (node_peak.exists(slot) && (!any || node_peak[slot] > best)) begin
            best = node_peak[slot];
            any  = 1'b1;
          end
        end
      end
      outcome.max_value = best;
      outcome.found     = any;
      pending_maxima.push_back(outcome);
    end
  endfunction

  function automatic f2pm_pkg::req_t make_req(input logic kind, input int x, input int y,
                                              input logic signed [f2pm_pkg::VALUE_W-1:0] v);
    f2pm_pkg::req_t item;
    item.req_type = kind;
    item.x_coord  = f2pm_pkg::COORD_W'(x);
    item.y_coord  = f2pm_pkg::COORD_W'(y);
    item.value    = v;
    return item;
  endfunction

  function automatic logic [f2pm_pkg::COORD_W-1:0] pick_coord(input int n);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return f2pm_pkg::COORD_W'($urandom);
    if (pick == 2) return f2pm_pkg::COORD_W'(n);
    if (n == 0) return f2pm_pkg::COORD_W'($urandom_range(0, 3));
    return f2pm_pkg::COORD_W'($urandom_range(1, n));
  endfunction

  function automatic logic signed [f2pm_pkg::VALUE_W-1:0] pick_value();
    int pick;
    int near_zero;
    pick      = $urandom_range(0, 9);
    near_zero = int'($urandom_range(0, 200)) - 100;
    if (pick == 0) return VAL_MAX;
    if (pick == 1) return VAL_MIN;
    if (pick <= 4) return f2pm_pkg::VALUE_W'(near_zero);
    return f2pm_pkg::VALUE_W'({$urandom, $urandom});
  endfunction

  function automatic f2pm_pkg::req_t random_request(input int n, input bit noisy);
    f2pm_pkg::req_t item;
    item.req_type = ($urandom_range(0, 99) < 45) ? f2pm_pkg::REQ_UPDATE
                                                  : f2pm_pkg::REQ_QUERY;
    item.x_coord  = noisy ? f2pm_pkg::COORD_W'($urandom) : pick_coord(n);
    item.y_coord  = noisy ? f2pm_pkg::COORD_W'($urandom) : pick_coord(n);
    item.value    = pick_value();
    return item;
  endfunction

  task automatic send_req(input f2pm_pkg::req_t item);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall !== 1'b0) @(posedge clk);
    predict_prefix_max(item);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_maxima.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input bit is_write, input logic [f2pm_pkg::APB_DW-1:0] wdata,
                            output logic [f2pm_pkg::APB_DW-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= f2pm_pkg::ADDR_SIZE_IN_USE;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_size_reg();
    logic [f2pm_pkg::APB_DW-1:0] readback;
    apb_access(1'b0, '0, readback);
    if (readback[f2pm_pkg::SIZE_W-1:0] !== size_setting) begin
      report_mismatch($sformatf("size_in_use reads %0d, want %0d",
                                readback[f2pm_pkg::SIZE_W-1:0], size_setting));
    end
  endtask

  task automatic set_size(input int unsigned new_size);
    logic [f2pm_pkg::APB_DW-1:0] unused;
    wait_idle();
    apb_access(1'b1, f2pm_pkg::APB_DW'(new_size), unused);
    size_setting = f2pm_pkg::SIZE_W'(new_size);
    check_size_reg();
  endtask

  task automatic test_reset_value();
    check_size_reg();
  endtask

  task automatic test_directed_cases();
    send_req(make_req(f2pm_pkg::REQ_QUERY, 1024, 1024, '0));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 0, 0, VAL_MAX));
    send_req(make_req(f2pm_pkg::REQ_UPDATE, 1, 1, VAL_MIN));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 1, 1, '0));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 1024, 1024, '0));
    send_req(make_req(f2pm_pkg::REQ_UPDATE, 0, 5, 48'sd100));
    send_req(make_req(f2pm_pkg::REQ_UPDATE, 5, 0, 48'sd100));
    send_req(make_req(f2pm_pkg::REQ_UPDATE, 1025, 3, 48'sd200));
    send_req(make_req(f2pm_pkg::REQ_UPDATE, 2047, 2047, VAL_MAX));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 1024, 1024, '0));
    send_req(make_req(f2pm_pkg::REQ_UPDATE, 1024, 1024, VAL_MAX));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 1023, 1023, '0));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 2047, 2047, '0));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 0, 1024, '0));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 1024, 0, '0));
    send_req(make_req(f2pm_pkg::REQ_UPDATE, 512, 700, -48'sd5));
    send_req(make_req(f2pm_pkg::REQ_UPDATE, 3, 1000, 48'sd0));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 600, 1000, '0));
    send_req(make_req(f2pm_pkg::REQ_UPDATE, 1, 1024, 48'h0000_AAAA_5555));
    send_req(make_req(f2pm_pkg::REQ_UPDATE, 1024, 1, 48'h5555_AAAA_5555));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 1024, 1, '0));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 1, 1024, '0));
    send_req(make_req(f2pm_pkg::REQ_UPDATE, 1, 1, VAL_MIN + 48'sd1));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 1, 1, '0));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 2000, 3, '0));
  endtask

  task automatic test_size_extremes();
    set_size(0);
    send_req(make_req(f2pm_pkg::REQ_UPDATE, 1, 1, 48'sd77));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 1, 1, '0));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 2047, 2047, '0));
    set_size(1);
    send_req(make_req(f2pm_pkg::REQ_UPDATE, 1, 1, 48'sd9));
    send_req(make_req(f2pm_pkg::REQ_UPDATE, 2, 1, 48'sd500));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 1, 1, '0));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 5, 5, '0));
    set_size(2047);
    send_req(make_req(f2pm_pkg::REQ_QUERY, 1024, 1024, '0));
    send_req(make_req(f2pm_pkg::REQ_QUERY, 2047, 1, '0));
    set_size(1024);
    send_req(make_req(f2pm_pkg::REQ_QUERY, 700, 1024, '0));
  endtask

  // The response register fills while the receiver is held off, so the
  // following queries back up into the request side.
  task automatic test_output_backpressure();
    set_size(16);
    gaps_on       = 1'b0;
    long_hold_req = 1'b1;
    repeat (12) send_req(make_req(f2pm_pkg::REQ_QUERY, $urandom_range(1, 20),
                                  $urandom_range(1, 20), '0));
    wait_idle();
    gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (20) send_req(random_request(eff_size(), 1'b0));
    wait_idle();
    repeat (20) send_req(random_request(eff_size(), 1'b0));
  endtask

  task automatic test_random_phases();
    int unsigned phase_size [11] = '{16, 1, 2047, 7, 64, 2, 0, 300, 33, 1024, 9};
    int          phase_len  [11] = '{200, 100, 60, 200, 160, 120, 40, 100, 200, 60, 150};
    for (int p = 0; p < 11; p++) begin
      set_size(phase_size[p]);
      if (p == 10) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      repeat (phase_len[p]) begin
        send_req(random_request(eff_size(), $urandom_range(0, 99) < 15));
      end
    end
  endtask

  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left     = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      rsp_stall <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(0, 16);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (pending_maxima.size() == 0) begin
        report_mismatch("response transfer with no query pending");
      end else begin
        oldest_max = pending_maxima.pop_front();
        if (rsp.max_value !== oldest_max.max_value) begin
          report_mismatch($sformatf("max_value %0d, want %0d",
                                    rsp.max_value, oldest_max.max_value));
        end
        if (rsp.found !== oldest_max.found) begin
          report_mismatch($sformatf("found %0b, want %0b", rsp.found, oldest_max.found));
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_value();
    test_directed_cases();
    test_size_extremes();
    test_output_backpressure();
    test_drain_pause();
    test_random_phases();
    wait_idle();
    if (mismatch_count == 0 && pending_maxima.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
